// ===== rtl/calu8_pkg.sv =====
// Shared types and constants for the 8-bit ALU with flag register.
package calu8_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned OpW     = 5;
  localparam int unsigned BitIdxW = 3;

  // Stream packing widths
  localparam int unsigned InTdataW   = 24;  // a, b, bit index, check zero, pad
  localparam int unsigned OutTdataW  = 16;  // result, Z, N, H, C, pad
  localparam int unsigned InPadW     = InTdataW - (2 * DataW + BitIdxW + 1);
  localparam int unsigned OutPadW    = OutTdataW - (DataW + 4);

  typedef enum logic [OpW-1:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLC  = 5'd10,
    OP_RRC  = 5'd11,
    OP_RL   = 5'd12,
    OP_RR   = 5'd13,
    OP_SLA  = 5'd14,
    OP_SRA  = 5'd15,
    OP_SWAP = 5'd16,
    OP_BIT  = 5'd17,
    OP_RES  = 5'd18,
    OP_SET  = 5'd19,
    OP_CPL  = 5'd20,
    OP_SCF  = 5'd21,
    OP_CCF  = 5'd22
  } opcode_e;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

endpackage

// ===== rtl/cpu_alu_8bit_with_flags_top.sv =====
// 8-bit ALU with Z/N/H/C flag register, stream in and stream out.
//
//  channel  | dir | tdata (low bit up)                               | tuser
//  s_axis   | in  | operand_a[7:0] operand_b[15:8] bit_index[18:16] | opcode[4:0]
//           |     | check_zero[19] zero[23:20]                       |
//  m_axis   | out | result[7:0] Z[8] N[9] H[10] C[11] zero[15:12]    | write_back[0]
//
// One request per cycle sustained while the output is not stalled; a request
// passes through the input register, then ALU logic into the output register.
// The flag register updates when a request moves into the output register, so
// the next request sees the new flags with no bubble.
// Reset clears the valid bits and the flags to zero.
// An output stall holds the result; one more request waits in the input
// register, after which s_axis_tready drops.
module cpu_alu_8bit_with_flags_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // operand_a, operand_b, bit_index, check_zero (lowest first), zero padded
  input  logic [calu8_pkg::InTdataW-1:0] s_axis_tdata,
  // opcode
  input  logic [calu8_pkg::OpW-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result, zero_flag, subtract_flag, half_carry_flag, carry_flag, zero padded
  output logic [calu8_pkg::OutTdataW-1:0] m_axis_tdata,
  // write_back
  output logic                           m_axis_tuser
);
  import calu8_pkg::*;

  // input register
  logic               in_valid_q;
  logic [OpW-1:0]     op_q;
  logic [DataW-1:0]   a_q;
  logic [DataW-1:0]   b_q;
  logic [BitIdxW-1:0] bidx_q;
  logic               cz_q;

  // output register and flag state
  logic               out_valid_q;
  logic [DataW-1:0]   res_q;
  logic               wb_q;
  flags_t             flags_q;
  flags_t             flags_d;
  logic [DataW-1:0]   res_d;
  logic               wb_d;

  logic in_accept;
  logic advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q    <= s_axis_tdata[DataW-1:0];
      b_q    <= s_axis_tdata[2*DataW-1:DataW];
      bidx_q <= s_axis_tdata[2*DataW+BitIdxW-1:2*DataW];
      cz_q   <= s_axis_tdata[2*DataW+BitIdxW];
      op_q   <= s_axis_tuser;
    end
  end

  // ALU
  logic [DataW:0]   sum9;
  logic [DataW:0]   diff9;
  logic [4:0]       hsum5;
  logic [4:0]       hdiff5;
  logic             cin_add;
  logic             cin_sub;
  logic [DataW-1:0] bit_mask;
  logic             rot_c;

  always_comb begin
    cin_add  = (opcode_e'(op_q) == OP_ADC) ? flags_q.c : 1'b0;
    cin_sub  = (opcode_e'(op_q) == OP_SBC) ? flags_q.c : 1'b0;
    sum9     = {1'b0, a_q} + {1'b0, b_q} + {{DataW{1'b0}}, cin_add};
    hsum5    = {1'b0, a_q[3:0]} + {1'b0, b_q[3:0]} + {4'd0, cin_add};
    diff9    = {1'b0, a_q} - {1'b0, b_q} - {{DataW{1'b0}}, cin_sub};
    hdiff5   = {1'b0, a_q[3:0]} - {1'b0, b_q[3:0]} - {4'd0, cin_sub};
    bit_mask = {{(DataW-1){1'b0}}, 1'b1} << bidx_q;
    rot_c    = a_q[0];

    res_d   = a_q;
    wb_d    = 1'b1;
    flags_d = flags_q;

    case (opcode_e'(op_q))
      OP_ADD, OP_ADC: begin
        res_d   = sum9[DataW-1:0];
        flags_d = '{z: (sum9[DataW-1:0] == '0), n: 1'b0, h: hsum5[4], c: sum9[DataW]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        res_d   = diff9[DataW-1:0];
        flags_d = '{z: (diff9[DataW-1:0] == '0), n: 1'b1, h: hdiff5[4], c: diff9[DataW]};
        wb_d    = (opcode_e'(op_q) != OP_CP);
      end
      OP_AND: begin
        res_d   = a_q & b_q;
        flags_d = '{z: ((a_q & b_q) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        res_d   = a_q ^ b_q;
        flags_d = '{z: ((a_q ^ b_q) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        res_d   = a_q | b_q;
        flags_d = '{z: ((a_q | b_q) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC: begin
        res_d   = a_q + 8'd1;
        flags_d = '{z: (a_q == 8'hFF), n: 1'b0, h: (a_q[3:0] == 4'hF), c: flags_q.c};
      end
      OP_DEC: begin
        res_d   = a_q - 8'd1;
        flags_d = '{z: (a_q == 8'h01), n: 1'b1, h: (a_q[3:0] == 4'h0), c: flags_q.c};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR: begin
        case (opcode_e'(op_q))
          OP_RLC: begin
            res_d = {a_q[DataW-2:0], a_q[DataW-1]};
            rot_c = a_q[DataW-1];
          end
          OP_RL: begin
            res_d = {a_q[DataW-2:0], flags_q.c};
            rot_c = a_q[DataW-1];
          end
          OP_RRC:  res_d = {a_q[0], a_q[DataW-1:1]};
          default: res_d = {flags_q.c, a_q[DataW-1:1]};
        endcase
        // accumulator forms (check_zero low) keep Z clear
        flags_d = '{z: cz_q && (res_d == '0), n: 1'b0, h: 1'b0, c: rot_c};
      end
      OP_SLA: begin
        res_d   = {a_q[DataW-2:0], 1'b0};
        flags_d = '{z: (a_q[DataW-2:0] == '0), n: 1'b0, h: 1'b0, c: a_q[DataW-1]};
      end
      OP_SRA: begin
        res_d   = {a_q[DataW-1], a_q[DataW-1:1]};
        flags_d = '{z: (a_q[DataW-1:1] == '0), n: 1'b0, h: 1'b0, c: a_q[0]};
      end
      OP_SWAP: begin
        res_d   = {a_q[3:0], a_q[7:4]};
        flags_d = '{z: (a_q == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_BIT: begin
        wb_d    = 1'b0;
        flags_d = '{z: ((a_q & bit_mask) == '0), n: 1'b0, h: 1'b1, c: flags_q.c};
      end
      OP_RES:  res_d = a_q & ~bit_mask;
      OP_SET:  res_d = a_q | bit_mask;
      OP_CPL: begin
        res_d   = ~a_q;
        flags_d = '{z: flags_q.z, n: 1'b1, h: 1'b1, c: flags_q.c};
      end
      OP_SCF: begin
        wb_d    = 1'b0;
        flags_d = '{z: flags_q.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_CCF: begin
        wb_d    = 1'b0;
        flags_d = '{z: flags_q.z, n: 1'b0, h: 1'b0, c: !flags_q.c};
      end
      default: wb_d = 1'b0;  // unused codes: no operation
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
      wb_q  <= wb_d;
    end
  end

  // output flags are the current flag register, which loads with the result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, flags_q.c, flags_q.h, flags_q.n, flags_q.z,
                          res_q};
  assign m_axis_tuser  = wb_q;

endmodule

// ===== rtl/calu8_checker.sv =====
// Port-level checker for the ALU stream block, bound to the top level.
module calu8_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [calu8_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import calu8_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output changed");

  // input stalls only when both the input and output registers are full
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // an output that turns on came from an accepted request, via the input register
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output appeared without a request");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutTdataW-1:DataW+4] == '0)
    else $error("output padding not zero");

endmodule

bind cpu_alu_8bit_with_flags_top calu8_checker u_calu8_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
